FILE: rtl/core/rafd_pkg.sv
// Shared constants, register indexes and pipeline control types for the alpha fade.
package rafd_pkg;

  // Default geometry
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 16;

  // Pixel word layout
  localparam int unsigned ArgbBits   = 32;
  localparam int unsigned AlphaShift = 24;
  localparam int unsigned AlphaBits  = 8;
  localparam logic [31:0] RgbMask    = 32'h00FF_FFFF;
  localparam logic [7:0]  ByteMask   = 8'hFF;

  // Register index width and codes
  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_CENTER_X    = 2'd0,
    REG_CENTER_Y    = 2'd1,
    REG_FADE_RADIUS = 2'd2
  } cfg_reg_e;

  // Control and passthrough payload that travels with each pipeline stage
  typedef struct packed {
    logic                valid;
    logic [ArgbBits-1:0] argb;
  } pipe_ctl_t;

endpackage

FILE: rtl/core/rafd_dist.sv
// Two-stage squared distance: absolute offsets, then sum of squares.
module rafd_dist #(
  parameter int unsigned COORD_BITS = rafd_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  rafd_pkg::pipe_ctl_t         ctl_i,
  input  logic [COORD_BITS-1:0]       pixel_x_i,
  input  logic [COORD_BITS-1:0]       pixel_y_i,
  input  logic [COORD_BITS-1:0]       center_x_i,
  input  logic [COORD_BITS-1:0]       center_y_i,
  output rafd_pkg::pipe_ctl_t         ctl_o,
  output logic [2*COORD_BITS:0]       sq_o
);
  localparam int unsigned SqBits = 2 * COORD_BITS + 1;

  logic [COORD_BITS-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SqBits-1:0]     sq_d, sq_q;
  logic                  v0_q, v1_q;
  logic [31:0]           argb0_q, argb1_q;

  // Absolute offsets from the centre
  always_comb begin
    dx_d = (pixel_x_i >= center_x_i) ? pixel_x_i - center_x_i : center_x_i - pixel_x_i;
    dy_d = (pixel_y_i >= center_y_i) ? pixel_y_i - center_y_i : center_y_i - pixel_y_i;
    sq_d = SqBits'(dx_q) * SqBits'(dx_q) + SqBits'(dy_q) * SqBits'(dy_q);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= ctl_i.valid;
      v1_q <= v0_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      argb0_q <= ctl_i.argb;
      sq_q    <= sq_d;
      argb1_q <= argb0_q;
    end
  end

  assign ctl_o = '{valid: v1_q, argb: argb1_q};
  assign sq_o  = sq_q;

endmodule

FILE: rtl/core/rafd_sqrt.sv
// Pipelined digit-by-digit square root of the scaled squared distance, one bit per stage.
module rafd_sqrt #(
  parameter int unsigned COORD_BITS = rafd_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = rafd_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  rafd_pkg::pipe_ctl_t              ctl_i,
  input  logic [2*COORD_BITS:0]            sq_i,
  output rafd_pkg::pipe_ctl_t              ctl_o,
  output logic [COORD_BITS+FRAC_BITS:0]    root_o
);
  localparam int unsigned RootBits = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned RadBits  = 2 * RootBits;
  localparam int unsigned RemBits  = RootBits + 2;

  logic [RadBits-1:0]  rad_q  [RootBits+1];
  logic [RemBits-1:0]  rem_q  [RootBits+1];
  logic [RootBits-1:0] root_q [RootBits+1];
  logic [31:0]         argb_q [RootBits+1];
  logic                v_q    [RootBits+1];

  // Stage zero: scale by two to the power of twice the fraction width
  assign rad_q[0]  = {1'b0, sq_i, {(2*FRAC_BITS){1'b0}}};
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign argb_q[0] = ctl_i.argb;
  assign v_q[0]    = ctl_i.valid;

  for (genvar s = 0; s < RootBits; s++) begin : g_stage
    logic [RemBits+1:0]  remx;
    logic [RemBits+1:0]  trial;
    logic                take;
    logic [RemBits-1:0]  rem_d;
    logic [RootBits-1:0] root_d;

    // Bring down two bits and try the next root digit
    always_comb begin
      remx   = {rem_q[s], rad_q[s][RadBits-1 -: 2]};
      trial  = (RemBits+2)'({root_q[s], 2'b01});
      take   = (remx >= trial);
      rem_d  = take ? RemBits'(remx - trial) : RemBits'(remx);
      root_d = {root_q[s][RootBits-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1]  <= {rad_q[s][RadBits-3:0], 2'b00};
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
        argb_q[s+1] <= argb_q[s];
      end
    end
  end

  assign ctl_o  = '{valid: v_q[RootBits], argb: argb_q[RootBits]};
  assign root_o = root_q[RootBits];

endmodule

FILE: rtl/core/rafd_scale.sv
// Alpha scaling: radius compare, multiply, then an eight-stage restoring divide.
module rafd_scale #(
  parameter int unsigned COORD_BITS = rafd_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = rafd_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  rafd_pkg::pipe_ctl_t           ctl_i,
  input  logic [COORD_BITS+FRAC_BITS:0] dist_i,
  input  logic [COORD_BITS-1:0]         radius_i,
  output rafd_pkg::pipe_ctl_t           ctl_o
);
  localparam int unsigned RadBits = COORD_BITS + FRAC_BITS;
  localparam int unsigned AB      = rafd_pkg::AlphaBits;
  localparam int unsigned NumBits = RadBits + AB;
  localparam int unsigned AS      = rafd_pkg::AlphaShift;

  logic [RadBits-1:0] rfx;
  logic [RadBits:0]   rfx_w;
  logic               outside;
  logic [RadBits-1:0] diff_d, diff_q;
  logic [AB-1:0]      alpha_d, alpha_q;
  logic [NumBits-1:0] num_d, num_q;
  logic               va_q, vb_q;
  logic [31:0]        argba_q, argbb_q;

  logic [NumBits-1:0] rem_q  [AB+1];
  logic [AB-1:0]      quo_q  [AB+1];
  logic [31:0]        argb_q [AB+1];
  logic               v_q    [AB+1];

  // Compare with the radius and form the remaining span
  always_comb begin
    rfx     = {radius_i, {FRAC_BITS{1'b0}}};
    rfx_w   = {1'b0, rfx};
    outside = (dist_i >= rfx_w);
    diff_d  = outside ? '0 : RadBits'(rfx_w - dist_i);
    alpha_d = ctl_i.argb[AS +: AB] & rafd_pkg::ByteMask;
    num_d   = NumBits'(alpha_q) * NumBits'(diff_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= ctl_i.valid;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= diff_d;
      alpha_q <= alpha_d;
      argba_q <= ctl_i.argb;
      num_q   <= num_d;
      argbb_q <= argba_q;
    end
  end

  assign rem_q[0]  = num_q;
  assign quo_q[0]  = '0;
  assign argb_q[0] = argbb_q;
  assign v_q[0]    = vb_q;

  // One quotient bit per stage, most significant first; a zero radius yields zero
  for (genvar s = 0; s < AB; s++) begin : g_div
    localparam int unsigned Sh = AB - 1 - s;
    logic [NumBits-1:0] dvs;
    logic               take;

    always_comb begin
      dvs  = NumBits'(rfx) << Sh;
      take = (dvs != '0) && (rem_q[s] >= dvs);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? rem_q[s] - dvs : rem_q[s];
        quo_q[s+1]  <= {quo_q[s][AB-2:0], take};
        argb_q[s+1] <= argb_q[s];
      end
    end
  end

  assign ctl_o = '{valid: v_q[AB],
                   argb: {quo_q[AB], argb_q[AB][AS-1:0]}};

endmodule

FILE: rtl/core/radial_alpha_fade.sv
// Top level of the radial alpha fade: config registers, stream ports, pipeline chain.
// Pipeline: 2 distance stages, one square root stage per root bit,
// then compare, multiply and 8 divide stages.
// Throughput: one pixel per cycle; the whole pipeline holds while the output waits.
// Reset: asynchronous active low; clears all valid bits, centre to 0, radius to 1.
module radial_alpha_fade #(
  parameter int unsigned COORD_BITS = rafd_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = rafd_pkg::FracBitsDef,
  localparam int unsigned InBits    = ((2 * COORD_BITS + 32 + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pixel_x, pixel_y, pixel_argb, zero fill
  input  logic [InBits-1:0]                  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // faded_argb
  output logic [31:0]                        m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rafd_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [COORD_BITS-1:0]              cfg_data_i
);
  logic [COORD_BITS-1:0] center_x_q, center_y_q, radius_q;
  logic                  en;
  rafd_pkg::pipe_ctl_t   in_ctl, dist_ctl, sqrt_ctl, out_ctl;
  logic [2*COORD_BITS:0] sq;
  logic [COORD_BITS+FRAC_BITS:0] root;

  // Hold every pipeline stage and the input while the output request waits
  assign en              = !out_ctl.valid || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= COORD_BITS'(1);
    end else if (cfg_valid_i) begin
      case (rafd_pkg::cfg_reg_e'(cfg_index_i))
        rafd_pkg::REG_CENTER_X:    center_x_q <= cfg_data_i;
        rafd_pkg::REG_CENTER_Y:    center_y_q <= cfg_data_i;
        rafd_pkg::REG_FADE_RADIUS: radius_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ctl = '{valid: s_axis_tvalid_i,
                    argb: s_axis_tdata_i[2*COORD_BITS +: 32]};

  rafd_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(in_ctl),
    .pixel_x_i(s_axis_tdata_i[COORD_BITS-1:0]),
    .pixel_y_i(s_axis_tdata_i[COORD_BITS +: COORD_BITS]),
    .center_x_i(center_x_q), .center_y_i(center_y_q),
    .ctl_o(dist_ctl), .sq_o(sq)
  );

  rafd_sqrt #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(dist_ctl), .sq_i(sq),
    .ctl_o(sqrt_ctl), .root_o(root)
  );

  rafd_scale #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_scale (
    .clk_i, .rst_ni, .en_i(en), .ctl_i(sqrt_ctl), .dist_i(root),
    .radius_i(radius_q), .ctl_o(out_ctl)
  );

  assign m_axis_tvalid_o = out_ctl.valid;
  assign m_axis_tdata_o  = out_ctl.argb;

endmodule

FILE: rtl/core/rafd_checker.sv
// Port-level checks for the radial alpha fade, bound to the top level.
module rafd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        cfg_ready_o
);
  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output changed");

  // Input side advances exactly when the output can drain
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output drain");

  // No result right after reset release
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result present after reset");

  // Config channel never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config channel stalled");
endmodule

bind radial_alpha_fade rafd_checker u_rafd_checker (
  .clk_i, .rst_ni, .s_axis_tready_o, .m_axis_tvalid_o, .m_axis_tready_i,
  .m_axis_tdata_o, .cfg_ready_o
);

FILE: tb/radial_alpha_fade_tb.sv
// Self-checking testbench for the radial alpha fade: random pixel streams over several geometries.
`timescale 1ns / 1ps

module radial_alpha_fade_tb;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned InBits    = 56;
  localparam int unsigned CoordMax  = 4095;
  localparam int unsigned WaitLimit = 4000;
  localparam int unsigned Drain     = 60;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // pixel_x, pixel_y, pixel_argb, zero fill
  logic [InBits-1:0]     s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // faded_argb
  logic [31:0]           m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [rafd_pkg::CfgIdxBits-1:0] cfg_index_i = rafd_pkg::REG_CENTER_X;
  logic [CoordBits-1:0]  cfg_data_i = '0;

  radial_alpha_fade dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the geometry registers
  logic [CoordBits-1:0] centre_x_q = '0;
  logic [CoordBits-1:0] centre_y_q = '0;
  logic [CoordBits-1:0] radius_q = 12'd1;

  logic [InBits-1:0] pixel_queue[$];
  logic [31:0]       faded_queue[$];
  int unsigned       mismatches = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       send_gap = 0;
  int unsigned       recv_gap = 0;
  bit                pixel_taken = 1'b0;
  bit                idle_off = 1'b0;

  // Floor of the square root, digit by digit
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Expected faded word for one request under the current geometry
  function automatic logic [31:0] fade_pixel(logic [InBits-1:0] w);
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    logic [31:0]          argb;
    logic [63:0]          dx;
    logic [63:0]          dy;
    logic [63:0]          dist_fx;
    logic [63:0]          rfx;
    logic [63:0]          alpha;
    px   = w[CoordBits-1:0];
    py   = w[2*CoordBits-1:CoordBits];
    argb = w[2*CoordBits+31:2*CoordBits];
    dx   = (px >= centre_x_q) ? 64'(px - centre_x_q) : 64'(centre_x_q - px);
    dy   = (py >= centre_y_q) ? 64'(py - centre_y_q) : 64'(centre_y_q - py);
    dist_fx = root_floor((dx * dx + dy * dy) << (2 * FracBits));
    rfx  = 64'(radius_q) << FracBits;
    alpha = 64'(argb[31:24]);
    if (dist_fx >= rfx) alpha = 0;
    else alpha = (alpha * (rfx - dist_fx)) / rfx;
    return {alpha[7:0], argb[23:0]};
  endfunction

  task automatic report_mismatch(input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: faded_argb got %h expected %h", got, want);
    mismatches++;
  endtask

  // Record accepted requests and check results
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      faded_queue.push_back(fade_pixel(s_axis_tdata_i));
      pixel_taken = 1'b1;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (faded_queue.size() == 0) begin
        $display("mismatch: unexpected result %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        if (m_axis_tdata_o !== faded_queue[0]) report_mismatch(m_axis_tdata_o, faded_queue[0]);
        void'(faded_queue.pop_front());
      end
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WaitLimit) begin
      $display("radial_alpha_fade regression: fail");
      $finish;
    end
  end

  // Drive pixel requests with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || pixel_taken)) begin
      pixel_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        s_axis_tdata_i  <= pixel_queue.pop_front();
        s_axis_tvalid_i <= 1'b1;
        if (!idle_off && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Stall the result side in bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!idle_off && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 8);
    end
  end

  task automatic write_reg(input rafd_pkg::cfg_reg_e idx, input logic [CoordBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == rafd_pkg::REG_CENTER_X) centre_x_q = val;
    else if (idx == rafd_pkg::REG_CENTER_Y) centre_y_q = val;
    else if (idx == rafd_pkg::REG_FADE_RADIUS) radius_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CoordBits-1:0] cx, input logic [CoordBits-1:0] cy,
                              input logic [CoordBits-1:0] rad);
    write_reg(rafd_pkg::REG_CENTER_X, cx);
    write_reg(rafd_pkg::REG_CENTER_Y, cy);
    write_reg(rafd_pkg::REG_FADE_RADIUS, rad);
  endtask

  function automatic logic [InBits-1:0] pack_pixel(int unsigned x, int unsigned y,
                                                   logic [31:0] argb);
    return {argb, y[CoordBits-1:0], x[CoordBits-1:0]};
  endfunction

  // Coordinate near the centre, clamped to the image
  function automatic int unsigned near_coord(int c);
    int v;
    v = c + $urandom_range(0, 2 * radius_q + 2) - radius_q - 1;
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return v;
  endfunction

  task automatic queue_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0)
        pixel_queue.push_back(pack_pixel($urandom_range(0, CoordMax),
                                         $urandom_range(0, CoordMax), $urandom));
      else
        pixel_queue.push_back(pack_pixel(near_coord(centre_x_q), near_coord(centre_y_q),
                                         $urandom));
    end
  endtask

  // Hold off until every result is back, then let the pipeline settle
  task automatic drain;
    wait (pixel_queue.size() == 0 && !s_axis_tvalid_i && faded_queue.size() == 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: centre, on the circle, far corner, extreme words
    pixel_queue.push_back(pack_pixel(0, 0, 32'hFFFF_FFFF));
    pixel_queue.push_back(pack_pixel(0, 0, 32'h0000_0000));
    pixel_queue.push_back(pack_pixel(1, 0, 32'hFFFF_FFFF));
    pixel_queue.push_back(pack_pixel(0, 1, 32'h80A5_5A01));
    pixel_queue.push_back(pack_pixel(CoordMax, CoordMax, 32'hFFFF_FFFF));
    drain();

    set_geometry(12'd2048, 12'd1000, 12'd100);
    write_reg(rafd_pkg::cfg_reg_e'(2'd3), 12'hFFF);
    pixel_queue.push_back(pack_pixel(2048, 1000, 32'hFF12_3456));
    pixel_queue.push_back(pack_pixel(2148, 1000, 32'hFFFF_FFFF));
    pixel_queue.push_back(pack_pixel(2048, 900, 32'hFFFF_FFFF));
    pixel_queue.push_back(pack_pixel(2108, 1080, 32'hFFFF_FFFF));
    pixel_queue.push_back(pack_pixel(2147, 1000, 32'hFFFF_FFFF));
    pixel_queue.push_back(pack_pixel(2049, 1000, 32'h01FF_FFFF));
    pixel_queue.push_back(pack_pixel(0, 0, 32'hFF00_0000));
    queue_random(200);
    drain();

    set_geometry(12'd4095, 12'd4095, 12'd4095);
    pixel_queue.push_back(pack_pixel(0, 0, 32'hFFFF_FFFF));
    pixel_queue.push_back(pack_pixel(0, 4095, 32'hFFFF_FFFF));
    pixel_queue.push_back(pack_pixel(4095, 4095, 32'hFFFF_FFFF));
    queue_random(200);
    drain();

    // Zero radius fades everything
    set_geometry(12'd0, 12'd4095, 12'd0);
    pixel_queue.push_back(pack_pixel(0, 4095, 32'hFFFF_FFFF));
    queue_random(50);
    drain();

    set_geometry(12'd0, 12'd0, 12'd1);
    queue_random(100);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_geometry(CoordBits'($urandom_range(0, CoordMax)),
                   CoordBits'($urandom_range(0, CoordMax)),
                   CoordBits'((p % 2 == 0) ? $urandom_range(1, 40)
                                           : $urandom_range(1, CoordMax)));
      queue_random(200);
      drain();
    end

    // Last stretch at full rate
    idle_off = 1'b1;
    set_geometry(CoordBits'($urandom_range(0, CoordMax)),
                 CoordBits'($urandom_range(0, CoordMax)),
                 CoordBits'($urandom_range(1, 300)));
    queue_random(250);
    drain();

    if (mismatches == 0) $display("radial_alpha_fade regression: pass");
    else $display("radial_alpha_fade regression: fail");
    $finish;
  end

endmodule
